// ===== rtl/rsa_pkg.sv =====
// Package for the running statistics accumulator.
// Holds the item structs, control and status structs, fixed widths, opcodes and the sequencer state type.
// Depends on nothing; every other file of the block uses it.
package rsa_pkg;

    // Field widths of the items.
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 24;

    // Accumulator widths: sum is Q.8 signed, sum of squares is Q.16 unsigned.
    localparam int SUM_W    = 40;
    localparam int SQSUM_W  = 2 * SAMPLE_W + COUNT_W;

    // Sample magnitude and its square.
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int PROD_W   = 2 * MAG_W;

    // Quotient widths: the mean magnitude never exceeds 2^(SAMPLE_W-1) and the
    // mean square never exceeds 2^(2*SAMPLE_W-2).
    localparam int MEANQ_W  = SAMPLE_W;
    localparam int VARQ_W   = 2 * SAMPLE_W - 1;

    // Square root: radicand and root widths.
    localparam int ROOT_W   = SAMPLE_W;
    localparam int RAD_W    = 2 * ROOT_W;

    // Shared compare/subtract unit width and iteration counter width.
    localparam int UNIT_W   = 33;
    localparam int STEP_W   = $clog2(VARQ_W);

    // Opcodes of an input item.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Input item.
    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] sample;
    } req_item_t;

    // Result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] mean;
        logic        [SAMPLE_W-1:0] std_deviation;
        logic        [COUNT_W-1:0]  sample_total;
        logic                       overflow;
    } rsp_item_t;

    // Control from the top level to the engine.
    typedef struct packed {
        logic start;
        logic ack;
        logic cfg_we;
        logic cfg_track;
    } eng_ctl_t;

    // Status from the engine to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_INIT,
        ST_MEAN_DIV,
        ST_MEAN_SQ,
        ST_VAR_DIV,
        ST_DIFF,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/rsa_csub.sv =====
// Shared compare/subtract unit of the running statistics accumulator.
// Gives a - b and whether a >= b; used for division, square root and difference.
// Depends on rsa_pkg for its width.
module rsa_csub (
    input  logic [rsa_pkg::UNIT_W-1:0] op_a,
    input  logic [rsa_pkg::UNIT_W-1:0] op_b,
    output logic [rsa_pkg::UNIT_W-1:0] diff,
    output logic                       ge
);

    logic borrow;

    // One subtractor; the borrow out decides the compare.
    assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
    assign ge = ~borrow;

endmodule

// ===== rtl/rsa_engine.sv =====
// Statistics registers and the sequencer that derives mean and deviation.
// Runs restoring division and square root through one shared rsa_csub.
// Depends on rsa_pkg and rsa_csub.
module rsa_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  rsa_pkg::eng_ctl_t  ctl,
    input  rsa_pkg::req_item_t item,
    output rsa_pkg::eng_stat_t stat,
    output rsa_pkg::rsp_item_t result
);

    rsa_pkg::state_t state_reg;
    rsa_pkg::state_t state_next;

    // Statistics.
    logic                                track_reg;
    logic signed [rsa_pkg::SAMPLE_W-1:0] min_reg;
    logic signed [rsa_pkg::SAMPLE_W-1:0] max_reg;
    logic signed [rsa_pkg::SUM_W-1:0]    sum_reg;
    logic        [rsa_pkg::SQSUM_W-1:0]  sq_reg;
    logic        [rsa_pkg::COUNT_W-1:0]  count_reg;
    logic                                ovf_reg;

    // Latched item.
    logic                                opcode_reg;
    logic signed [rsa_pkg::SAMPLE_W-1:0] sample_reg;

    // Working registers of the iterations.
    logic        [rsa_pkg::PROD_W-1:0]   prod_reg;
    logic        [rsa_pkg::COUNT_W-1:0]  rem_reg;
    logic        [rsa_pkg::VARQ_W-1:0]   shf_reg;
    logic        [rsa_pkg::RAD_W-1:0]    rad_reg;
    logic        [rsa_pkg::ROOT_W-1:0]   root_reg;
    logic        [rsa_pkg::STEP_W-1:0]   step_reg;
    logic                                neg_reg;
    logic signed [rsa_pkg::SAMPLE_W-1:0] mean_reg;

    // Combinational helpers.
    logic [rsa_pkg::UNIT_W-1:0]   unit_a;
    logic [rsa_pkg::UNIT_W-1:0]   unit_b;
    logic [rsa_pkg::UNIT_W-1:0]   unit_diff;
    logic                         unit_ge;
    logic [rsa_pkg::MAG_W-1:0]    mul_in;
    logic [rsa_pkg::PROD_W-1:0]   mul_out;
    logic [rsa_pkg::MAG_W-1:0]    sample_ext;
    logic [rsa_pkg::MAG_W-1:0]    sample_mag;
    logic [rsa_pkg::SUM_W-1:0]    sum_mag;
    logic [rsa_pkg::MEANQ_W-1:0]  mean_q;
    logic                         count_nz;

    rsa_csub u_csub (
        .op_a (unit_a),
        .op_b (unit_b),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    // Magnitudes of the latched sample and of the running sum.
    assign sample_ext = {sample_reg[rsa_pkg::SAMPLE_W-1], sample_reg};
    assign sample_mag = sample_reg[rsa_pkg::SAMPLE_W-1] ? (~sample_ext + 1'b1) : sample_ext;
    assign sum_mag    = sum_reg[rsa_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign mean_q     = shf_reg[rsa_pkg::MEANQ_W-1:0];
    assign count_nz   = (count_reg != '0);

    // The one squarer.
    assign mul_out = rsa_pkg::PROD_W'(mul_in) * rsa_pkg::PROD_W'(mul_in);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsa_pkg::ST_IDLE:
            begin
                if (ctl.start && !ctl.cfg_we)
                begin
                    state_next = rsa_pkg::ST_SQUARE;
                end
            end
            rsa_pkg::ST_SQUARE:    state_next = rsa_pkg::ST_ACCUM;
            rsa_pkg::ST_ACCUM:     state_next = rsa_pkg::ST_MEAN_INIT;
            rsa_pkg::ST_MEAN_INIT:
            begin
                state_next = count_nz ? rsa_pkg::ST_MEAN_DIV : rsa_pkg::ST_DONE;
            end
            rsa_pkg::ST_MEAN_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = rsa_pkg::ST_MEAN_SQ;
                end
            end
            rsa_pkg::ST_MEAN_SQ:   state_next = rsa_pkg::ST_VAR_DIV;
            rsa_pkg::ST_VAR_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = rsa_pkg::ST_DIFF;
                end
            end
            rsa_pkg::ST_DIFF:      state_next = rsa_pkg::ST_SQRT;
            rsa_pkg::ST_SQRT:
            begin
                if (step_reg == '0)
                begin
                    state_next = rsa_pkg::ST_DONE;
                end
            end
            rsa_pkg::ST_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = rsa_pkg::ST_IDLE;
                end
            end
            default:               state_next = rsa_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared unit and the squarer.
    always_comb
    begin
        unit_a = '0;
        unit_b = '0;
        mul_in = '0;
        unique case (state_reg)
            rsa_pkg::ST_SQUARE:
            begin
                mul_in = sample_mag;
            end
            rsa_pkg::ST_MEAN_DIV, rsa_pkg::ST_VAR_DIV:
            begin
                unit_a = rsa_pkg::UNIT_W'({rem_reg, shf_reg[rsa_pkg::VARQ_W-1]});
                unit_b = rsa_pkg::UNIT_W'(count_reg);
            end
            rsa_pkg::ST_MEAN_SQ:
            begin
                mul_in = rsa_pkg::MAG_W'(mean_q);
            end
            rsa_pkg::ST_DIFF:
            begin
                unit_a = rsa_pkg::UNIT_W'(shf_reg);
                unit_b = rsa_pkg::UNIT_W'(prod_reg[rsa_pkg::VARQ_W-1:0]);
            end
            rsa_pkg::ST_SQRT:
            begin
                unit_a = rsa_pkg::UNIT_W'({rem_reg, rad_reg[rsa_pkg::RAD_W-1 -: 2]});
                unit_b = rsa_pkg::UNIT_W'({root_reg, 2'b01});
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
                mul_in = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Statistics registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= 1'b1;
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (state_reg == rsa_pkg::ST_IDLE && ctl.cfg_we)
        begin
            // A configuration write also clears the statistics.
            track_reg <= ctl.cfg_track;
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (state_reg == rsa_pkg::ST_ACCUM)
        begin
            ovf_reg <= 1'b0;
            if (opcode_reg == rsa_pkg::OP_CLEAR)
            begin
                min_reg   <= '0;
                max_reg   <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                count_reg <= '0;
            end
            else if (&count_reg)
            begin
                // Full count: the sample is dropped and flagged.
                ovf_reg <= 1'b1;
            end
            else
            begin
                if (track_reg)
                begin
                    if (!count_nz)
                    begin
                        min_reg <= sample_reg;
                        max_reg <= sample_reg;
                    end
                    else
                    begin
                        if (sample_reg > max_reg)
                        begin
                            max_reg <= sample_reg;
                        end
                        if (sample_reg < min_reg)
                        begin
                            min_reg <= sample_reg;
                        end
                    end
                end
                sum_reg   <= sum_reg + {{(rsa_pkg::SUM_W - rsa_pkg::SAMPLE_W)
                                         {sample_reg[rsa_pkg::SAMPLE_W-1]}}, sample_reg};
                sq_reg    <= sq_reg + rsa_pkg::SQSUM_W'(prod_reg);
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Item latch and iteration datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rsa_pkg::ST_IDLE:
            begin
                if (ctl.start)
                begin
                    opcode_reg <= item.opcode;
                    sample_reg <= item.sample;
                end
            end
            rsa_pkg::ST_SQUARE:
            begin
                prod_reg <= mul_out;
            end
            rsa_pkg::ST_MEAN_INIT:
            begin
                // Quotient fits MEANQ_W bits, so start with the high part as remainder.
                neg_reg  <= sum_reg[rsa_pkg::SUM_W-1];
                rem_reg  <= sum_mag[rsa_pkg::SUM_W-1 -: rsa_pkg::COUNT_W];
                shf_reg  <= {sum_mag[rsa_pkg::MEANQ_W-1:0],
                             (rsa_pkg::VARQ_W - rsa_pkg::MEANQ_W)'(0)};
                step_reg <= rsa_pkg::STEP_W'(rsa_pkg::MEANQ_W - 1);
            end
            rsa_pkg::ST_MEAN_DIV, rsa_pkg::ST_VAR_DIV:
            begin
                // One restoring division step: quotient bits shift in at the bottom.
                rem_reg  <= unit_ge ? unit_diff[rsa_pkg::COUNT_W-1:0]
                                    : unit_a[rsa_pkg::COUNT_W-1:0];
                shf_reg  <= {shf_reg[rsa_pkg::VARQ_W-2:0], unit_ge};
                step_reg <= step_reg - 1'b1;
            end
            rsa_pkg::ST_MEAN_SQ:
            begin
                // Keep the signed mean, square it and set up the mean-square division.
                mean_reg <= neg_reg ? (~mean_q + 1'b1) : mean_q;
                prod_reg <= mul_out;
                rem_reg  <= sq_reg[rsa_pkg::VARQ_W +: rsa_pkg::COUNT_W];
                shf_reg  <= sq_reg[rsa_pkg::VARQ_W-1:0];
                step_reg <= rsa_pkg::STEP_W'(rsa_pkg::VARQ_W - 1);
            end
            rsa_pkg::ST_DIFF:
            begin
                // Variance, or zero when the mean square does not exceed mean^2.
                rad_reg  <= unit_ge ? rsa_pkg::RAD_W'(unit_diff) : '0;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= rsa_pkg::STEP_W'(rsa_pkg::ROOT_W - 1);
            end
            rsa_pkg::ST_SQRT:
            begin
                // One digit of the restoring square root, two radicand bits per step.
                rem_reg  <= unit_ge ? unit_diff[rsa_pkg::COUNT_W-1:0]
                                    : unit_a[rsa_pkg::COUNT_W-1:0];
                root_reg <= {root_reg[rsa_pkg::ROOT_W-2:0], unit_ge};
                rad_reg  <= {rad_reg[rsa_pkg::RAD_W-3:0], 2'b00};
                step_reg <= step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Status and result.
    always_comb
    begin
        stat.idle = (state_reg == rsa_pkg::ST_IDLE);
        stat.done = (state_reg == rsa_pkg::ST_DONE);

        result.minimum       = (track_reg && count_nz) ? min_reg : '0;
        result.maximum       = (track_reg && count_nz) ? max_reg : '0;
        result.mean          = count_nz ? mean_reg : '0;
        result.std_deviation = count_nz ? root_reg : '0;
        result.sample_total  = count_reg;
        result.overflow      = ovf_reg;
    end

endmodule

// ===== rtl/running_statistics_accumulator_core.sv =====
// Running statistics accumulator, top level: handshakes and result register.
// Tracks min, max, mean, standard deviation and count of signed Q7.8 samples.
// Depends on rsa_pkg and rsa_engine.
//
// Usage:
//   req channel (req_valid, req_stall, req_item): one item adds a sample or,
//   with the clear opcode, zeros the statistics. An item is taken at a clock
//   edge with req_valid high and req_stall low.
//   rsp channel (rsp_valid, rsp_stall, rsp_item): exactly one result per item,
//   held in an output register until the receiver drops rsp_stall.
//   cfg_write_en / cfg_write_data write the min/max tracking enable; every
//   write also clears the statistics. Write only while the block is idle.
// Sequence: after acceptance an add runs squaring, update and set-up, a
//   16-step mean division, squaring of the mean, a 31-step mean-square
//   division, a difference and a 16-step square root, and then loads the
//   output register; divisions, difference and root share one subtractor.
//   A clear goes from set-up straight to the load. No new item is accepted
//   until the result of the last one is loaded into the output register.
//   req_stall is high from acceptance until the result reaches the output
//   register, and during a configuration write.
// Stall: while rsp_stall holds a result, the next item may be accepted; its
//   result waits in the engine until the output register frees up.
// Reset: rst_n clears all statistics, sets tracking on and empties the output.
module running_statistics_accumulator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rsa_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsa_pkg::rsp_item_t rsp_item,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data
);

    rsa_pkg::eng_ctl_t  ctl;
    rsa_pkg::eng_stat_t stat;
    rsa_pkg::rsp_item_t result;

    logic               rsp_valid_reg;
    rsa_pkg::rsp_item_t rsp_item_reg;
    logic               load;

    rsa_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (req_item),
        .stat   (stat),
        .result (result)
    );

    // The output register takes a finished result when it is empty or draining.
    assign load = stat.done && (!rsp_valid_reg || !rsp_stall);

    // Engine control.
    always_comb
    begin
        ctl.start     = req_valid && stat.idle;
        ctl.ack       = load;
        ctl.cfg_we    = cfg_write_en;
        ctl.cfg_track = cfg_write_data;
    end

    // No item is taken in the cycle of a configuration write.
    assign req_stall = ~stat.idle | cfg_write_en;

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_item_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ===== tb/tb_running_statistics_accumulator_core.sv =====
`timescale 1ns / 100ps
// Testbench for the running statistics accumulator top level.
// Depends on rsa_pkg and running_statistics_accumulator_core; checks every result item
// against a behavioral model of min, max, mean, deviation and count kept in a scoreboard.
module tb_running_statistics_accumulator_core;

    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 100;

    // Scoreboard: predicts each result from its own copy of the statistics.
    class stats_scoreboard;
        logic                                track_on;
        logic signed [rsa_pkg::SAMPLE_W-1:0] low_mark;
        logic signed [rsa_pkg::SAMPLE_W-1:0] high_mark;
        longint                              sum_acc;
        longint unsigned                     square_acc;
        logic        [rsa_pkg::COUNT_W-1:0]  count_acc;
        rsa_pkg::rsp_item_t                  expected_stats[$];
        int                                  errors;

        function new();
            track_on = 1'b1;
            errors   = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            low_mark   = '0;
            high_mark  = '0;
            sum_acc    = 0;
            square_acc = 0;
            count_acc  = '0;
        endfunction

        // A register write sets tracking and also clears the statistics.
        function void configure(input logic track);
            track_on = track;
            clear_stats();
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        // Integer square root, built one result bit at a time from the top.
        function logic [rsa_pkg::SAMPLE_W-1:0] floor_root(input longint unsigned x);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = rsa_pkg::SAMPLE_W; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x)
                    root = trial;
            end
            if (root > {rsa_pkg::SAMPLE_W{1'b1}})
                return {rsa_pkg::SAMPLE_W{1'b1}};
            return root[rsa_pkg::SAMPLE_W-1:0];
        endfunction

        // Update the statistics with one accepted item and queue its result.
        function void note_request(input rsa_pkg::req_item_t it);
            rsa_pkg::rsp_item_t                  r;
            logic signed [rsa_pkg::SAMPLE_W-1:0] s;
            longint                              sv;
            longint                              mean_val;
            longint unsigned                     mag;
            longint unsigned                     amag;
            longint unsigned                     q;
            longint unsigned                     m2;
            r = '0;
            if (it.opcode == rsa_pkg::OP_CLEAR)
            begin
                clear_stats();
            end
            else if (count_acc == {rsa_pkg::COUNT_W{1'b1}})
            begin
                r.overflow = 1'b1;
            end
            else
            begin
                s   = it.sample;
                sv  = longint'(s);
                mag = (sv < 0) ? longint'(-sv) : longint'(sv);
                if (track_on)
                begin
                    if (count_acc == '0)
                    begin
                        low_mark  = s;
                        high_mark = s;
                    end
                    else
                    begin
                        if (s > high_mark)
                            high_mark = s;
                        if (s < low_mark)
                            low_mark = s;
                    end
                end
                sum_acc    = sum_acc + sv;
                square_acc = square_acc + mag * mag;
                count_acc  = count_acc + 1'b1;
            end

            // Derived outputs are all zero while the count is zero.
            if (count_acc != '0)
            begin
                if (track_on)
                begin
                    r.minimum = low_mark;
                    r.maximum = high_mark;
                end
                amag     = (sum_acc < 0) ? longint'(-sum_acc) : longint'(sum_acc);
                amag     = amag / longint'(count_acc);
                mean_val = (sum_acc < 0) ? -longint'(amag) : longint'(amag);
                r.mean   = mean_val[rsa_pkg::SAMPLE_W-1:0];
                q        = square_acc / longint'(count_acc);
                m2       = amag * amag;
                if (q > m2)
                    r.std_deviation = floor_root(q - m2);
            end
            r.sample_total = count_acc;
            expected_stats.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_response(input rsa_pkg::rsp_item_t got);
            rsa_pkg::rsp_item_t exp_r;
            if (expected_stats.size() == 0)
            begin
                $error("result item with no prediction waiting: %p", got);
                errors++;
                return;
            end
            exp_r = expected_stats.pop_front();
            if (got.minimum !== exp_r.minimum)
            begin
                $error("minimum: expected %0d, got %0d", exp_r.minimum, got.minimum);
                errors++;
            end
            if (got.maximum !== exp_r.maximum)
            begin
                $error("maximum: expected %0d, got %0d", exp_r.maximum, got.maximum);
                errors++;
            end
            if (got.mean !== exp_r.mean)
            begin
                $error("mean: expected %0d, got %0d", exp_r.mean, got.mean);
                errors++;
            end
            if (got.std_deviation !== exp_r.std_deviation)
            begin
                $error("std_deviation: expected %0d, got %0d",
                       exp_r.std_deviation, got.std_deviation);
                errors++;
            end
            if (got.sample_total !== exp_r.sample_total)
            begin
                $error("sample_total: expected %0d, got %0d",
                       exp_r.sample_total, got.sample_total);
                errors++;
            end
            if (got.overflow !== exp_r.overflow)
            begin
                $error("overflow: expected %0b, got %0b", exp_r.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    rsa_pkg::req_item_t req_item;
    logic               rsp_valid;
    logic               rsp_stall;
    rsa_pkg::rsp_item_t rsp_item;
    logic               cfg_write_en;
    logic               cfg_write_data;

    stats_scoreboard sb;
    int              send_gap_pct;
    int              recv_stall_pct;
    int              hold_request;
    int              quiet_cycles;
    logic [rsa_pkg::SAMPLE_W-1:0] last_sample;

    running_statistics_accumulator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_item       (req_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_item);
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_running_statistics_accumulator_core NOT OK");
            $finish;
        end
    end

    function automatic rsa_pkg::req_item_t add_item(input logic [rsa_pkg::SAMPLE_W-1:0] s);
        rsa_pkg::req_item_t it;
        it.opcode = rsa_pkg::OP_ADD;
        it.sample = s;
        return it;
    endfunction

    function automatic rsa_pkg::req_item_t clear_item(input logic [rsa_pkg::SAMPLE_W-1:0] s);
        rsa_pkg::req_item_t it;
        it.opcode = rsa_pkg::OP_CLEAR;
        it.sample = s;
        return it;
    endfunction

    // Offer one item after a random gap and wait until the block takes it.
    // Valid stays high after acceptance so back-to-back items need no extra edge.
    task automatic send_item(input rsa_pkg::req_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(it);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_track(input logic v);
        drain();
        repeat (8) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.configure(v);
    endtask

    // Random sample: full range, small values, extremes, or a repeat.
    function automatic logic [rsa_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        int          small_val;
        sel = $urandom_range(99);
        if (sel < 40)
            return rsa_pkg::SAMPLE_W'($urandom());
        if (sel < 70)
        begin
            small_val = int'($urandom_range(1024)) - 512;
            return small_val[rsa_pkg::SAMPLE_W-1:0];
        end
        if (sel < 85)
        begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                3: return 16'h0001;
                default: return 16'h0000;
            endcase
        end
        return last_sample;
    endfunction

    // One random phase: set tracking, then mostly adds with occasional clears.
    task automatic run_phase(input int gap_pct, input int stall_pct, input logic track,
                             input int n_items, input bit with_pressure);
        rsa_pkg::req_item_t it;
        write_track(track);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (with_pressure && i == n_items / 2)
                hold_request = LONG_HOLD;
            if (with_pressure && i == (3 * n_items) / 4)
                drain();
            if ($urandom_range(99) < 3)
            begin
                it = clear_item(rsa_pkg::SAMPLE_W'($urandom()));
            end
            else
            begin
                last_sample = pick_sample();
                it = add_item(last_sample);
            end
            send_item(it);
        end
    endtask

    // Main sequence.
    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_item       = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        hold_request   = 0;
        last_sample    = '0;
        send_gap_pct   = 32;
        recv_stall_pct = 56;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clear when empty, first sample, extremes, truncation toward zero.
        send_item(clear_item(16'h0000));
        send_item(add_item(16'h7FFF));
        send_item(add_item(16'h8000));
        send_item(add_item(16'hFFFF));
        send_item(add_item(16'h0000));
        send_item(add_item(16'h0001));
        send_item(clear_item(16'h5A5A));
        send_item(add_item(16'hFFFD));
        send_item(add_item(16'hFFFE));
        // Identical samples give zero deviation.
        send_item(clear_item(16'hFFFF));
        send_item(add_item(16'h0100));
        send_item(add_item(16'h0100));
        send_item(add_item(16'h0100));
        // Tracking off: min and max read zero.
        write_track(1'b0);
        send_item(add_item(16'h0064));
        send_item(add_item(16'hFF9C));
        send_item(add_item(16'h7FFF));
        send_item(clear_item(16'h0000));
        send_item(add_item(16'h8000));
        // Tracking back on after a write that clears.
        write_track(1'b1);
        send_item(add_item(16'hFFFB));
        send_item(add_item(16'h8000));

        // Random phases with the three idling patterns.
        run_phase(32, 56, 1'b1, 330, 1'b1);
        run_phase(56, 32, 1'b0, 330, 1'b0);
        run_phase(0, 0, 1'b1, 340, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_running_statistics_accumulator_core OK");
        else
            $display("tb_running_statistics_accumulator_core NOT OK");
        $finish;
    end
endmodule
